// ===== src/light_gate_speed_timer_top_macros.svh =====
// Assertion macros used by the light gate speed timer datapath.
`ifndef LIGHT_GATE_SPEED_TIMER_TOP_MACROS_SVH
`define LIGHT_GATE_SPEED_TIMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LGST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgst assertion failed");
`define LGST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgst assertion failed");
`else
`define LGST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LGST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/lgst_pkg.sv =====
// Types and constants of the light gate speed timer.
package lgst_pkg;

    localparam int DIST_W    = 8;
    localparam int ELAPSED_W = 32;
    localparam int SPEED_W   = 28;
    localparam logic [DIST_W-1:0] DIST_RESET = 8'd9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic step;
        logic load_num;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== src/lgst_ctrl.sv =====
// Controller state machine of the light gate speed timer.
module lgst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lgst_pkg::t_sts i_sts,
    output lgst_pkg::t_cmd o_cmd
);
    import lgst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.step = i_in_valid;
                if (i_in_valid && i_sts.hit) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.load_num = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lgst_dp.sv =====
// Datapath: gate edge detection, tick stamps, speed divider, output register.
`include "light_gate_speed_timer_top_macros.svh"

module lgst_dp #(
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_gate_a_level,
    input  logic                            i_gate_b_level,
    input  logic                            i_cfg_valid,
    input  logic [lgst_pkg::DIST_W-1:0]     i_cfg_gate_distance_cm,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [lgst_pkg::ELAPSED_W-1:0]  o_elapsed_ticks,
    output logic [lgst_pkg::SPEED_W-1:0]    o_speed_cmps,
    input  lgst_pkg::t_cmd                  i_cmd,
    output lgst_pkg::t_sts                  o_sts
);
    import lgst_pkg::*;

    localparam int NUM_W = DIST_W + $clog2(TICKS_PER_SECOND + 1);
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] TPS = NUM_W'(TICKS_PER_SECOND);

    logic                 r_last_a;
    logic                 r_last_b;
    logic                 r_armed;
    logic [ELAPSED_W-1:0] r_tick;
    logic [ELAPSED_W-1:0] r_stamp;
    logic [DIST_W-1:0]    r_dist;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [ELAPSED_W-1:0] r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    logic [ELAPSED_W-1:0] r_out_elapsed;
    logic [SPEED_W-1:0]   r_out_speed;

    logic                 w_fall_a;
    logic                 w_armed;
    logic [ELAPSED_W-1:0] w_stamp;
    logic                 w_hit;
    logic [ELAPSED_W:0]   w_rem_sh;
    logic [ELAPSED_W:0]   w_rem_sub;
    logic                 w_qbit;
    logic [SPEED_W-1:0]   n_speed;

    // A is evaluated before B within one word
    assign w_fall_a = r_last_a & ~i_gate_a_level;
    assign w_armed  = w_fall_a | r_armed;
    assign w_stamp  = w_fall_a ? r_tick : r_stamp;
    assign w_hit    = w_armed & r_last_b & ~i_gate_b_level;

    // restoring divide, one quotient bit per cycle
    assign w_rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_elapsed};
    assign w_qbit    = ~w_rem_sub[ELAPSED_W];

    assign n_speed = (r_elapsed == '0) ? '0 : SPEED_W'(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a <= 1'b1;
            r_last_b <= 1'b1;
            r_armed  <= 1'b0;
            r_tick   <= '0;
            r_stamp  <= '0;
            r_dist   <= DIST_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_dist <= i_cfg_gate_distance_cm;
            end
            if (i_cmd.step) begin
                r_last_a <= i_gate_a_level;
                r_last_b <= i_gate_b_level;
                r_tick   <= r_tick + 1'b1;
                if (w_hit) begin
                    r_armed <= 1'b0;
                    r_stamp <= '0;
                end else begin
                    r_armed <= w_armed;
                    r_stamp <= w_stamp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_hit) begin
            r_elapsed <= r_tick - w_stamp;
        end
        if (i_cmd.load_num) begin
            r_quo <= NUM_W'(r_dist) * TPS;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_rem_sub[ELAPSED_W-1:0] : w_rem_sh[ELAPSED_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_qbit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_elapsed <= r_elapsed;
            r_out_speed   <= n_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.hit      = w_hit;
    assign o_sts.div_last = (r_cnt == CNT_W'(NUM_W - 1));
    assign o_sts.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_elapsed_ticks = r_out_elapsed;
    assign o_speed_cmps    = r_out_speed;

    `LGST_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.load_out, !r_out_valid || i_out_ready)
    `LGST_ASSERT_NXT(a_hit_disarms, i_clk, i_rst_n, i_cmd.step && w_hit, !r_armed && r_stamp == '0)
    `LGST_ASSERT_NXT(a_tick_step, i_clk, i_rst_n, i_cmd.step, r_tick == $past(r_tick) + 32'd1)
    `LGST_ASSERT_NXT(a_tick_hold, i_clk, i_rst_n, !i_cmd.step, $stable(r_tick))

endmodule

// ===== src/light_gate_speed_timer_top.sv =====
// Light gate speed timer: one input word is one sample of both gates at one time-base
// tick; the tick counter advances once per accepted word. A word that causes no result
// leaves the timer ready for the next word. A word that completes a gate B edge while
// armed runs a restoring divider that yields one quotient bit per cycle; the next word
// is accepted only after the quotient and elapsed ticks are loaded into the output
// register, and that load waits while the previous result still waits there.
// The result waits in that register while new words are taken.
// The configuration register is always ready.
module light_gate_speed_timer_top #(
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_gate_a_level,
    input  logic                            i_gate_b_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lgst_pkg::ELAPSED_W-1:0]  o_elapsed_ticks,
    output logic [lgst_pkg::SPEED_W-1:0]    o_speed_cmps,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lgst_pkg::DIST_W-1:0]     i_cfg_gate_distance_cm
);
    import lgst_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lgst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lgst_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_gate_a_level         (i_gate_a_level),
        .i_gate_b_level         (i_gate_b_level),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_gate_distance_cm (i_cfg_gate_distance_cm),
        .i_out_ready            (i_out_ready),
        .o_out_valid            (o_out_valid),
        .o_elapsed_ticks        (o_elapsed_ticks),
        .o_speed_cmps           (o_speed_cmps),
        .i_cmd                  (w_cmd),
        .o_sts                  (w_sts)
    );

endmodule
